// ===== rtl/ehbi_pkg.sv =====
// ----------------------------------------------------------------------------
// ehbi_pkg
// Types and constants shared by the ELF hash bucket index block.
// ----------------------------------------------------------------------------
package ehbi_pkg;

	localparam int HASH_W    = 28;
	localparam int COUNT_W   = 29;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_STEPS = HASH_W;
	localparam int STEP_CW   = $clog2(DIV_STEPS);

	localparam logic [CFG_IDX_W-1:0] REG_CASE_FOLD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 2'd1;

	localparam logic [COUNT_W-1:0] BUCKET_COUNT_RST = 29'd1024;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       last_byte;
	} ehbi_in_t;

	typedef struct packed {
		logic [HASH_W-1:0] hash_value;
		logic [HASH_W-1:0] bucket_index;
	} ehbi_out_t;

	typedef struct packed {
		logic hash_en;   // accept a byte into the running hash
		logic start_div; // last byte: capture hash and start the modulo
		logic step;      // one restoring-division step
		logic load_out;  // move the result into the output register
	} ehbi_cmd_t;

endpackage

// ===== rtl/ehbi_ctrl.sv =====
// ----------------------------------------------------------------------------
// ehbi_ctrl
// Sequencer: byte handshake, modulo step count and result register valid.
// ----------------------------------------------------------------------------
module ehbi_ctrl
	import ehbi_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	input  logic      last_byte,
	output logic      byte_stall,
	output logic      result_valid,
	input  logic      result_stall,
	output ehbi_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	localparam logic [STEP_CW-1:0] LAST_STEP = STEP_CW'(DIV_STEPS - 1);

	logic [1:0]         state_q;
	logic [1:0]         state_nxt;
	logic [STEP_CW-1:0] cnt_q;
	logic               valid_q;
	logic               byte_fire;
	logic               out_free;

	assign byte_stall   = last_byte && (state_q != ST_IDLE);
	assign byte_fire    = byte_valid && !byte_stall;
	assign out_free     = !valid_q || !result_stall;
	assign result_valid = valid_q;

	always_comb begin
		cmd           = '0;
		cmd.hash_en   = byte_fire;
		cmd.start_div = byte_fire && last_byte;
		state_nxt     = state_q;
		case (state_q)
			ST_IDLE: begin
				if (byte_fire && last_byte) begin
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (cnt_q == LAST_STEP) begin
					state_nxt = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.load_out) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == LAST_STEP) |=> (state_q == ST_HOLD))
		else $error("modulo did not finish after the expected step count");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_valid && !byte_stall && last_byte) |-> (state_q == ST_IDLE))
		else $error("last byte taken while modulo busy");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> result_valid)
		else $error("result load lost");

	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (cnt_q == '0))
		else $error("step counter not cleared in idle");
`endif

endmodule

// ===== rtl/ehbi_datapath.sv =====
// ----------------------------------------------------------------------------
// ehbi_datapath
// Config registers, PJW/ELF running hash, bit-serial modulo, result register.
// ----------------------------------------------------------------------------
module ehbi_datapath
	import ehbi_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COUNT_W-1:0]   cfg_data,
	input  ehbi_in_t             byte_beat,
	input  ehbi_cmd_t            cmd,
	output ehbi_out_t            result_beat
);

	logic               case_fold_q;
	logic [COUNT_W-1:0] bucket_count_q;
	logic [HASH_W-1:0]  hash_q;
	logic [HASH_W-1:0]  hash_hold_q;
	logic [HASH_W-1:0]  dvd_q;
	logic [COUNT_W-1:0] rem_q;
	logic [COUNT_W-1:0] dsr_q;
	ehbi_out_t          out_q;

	logic [7:0]         c_fold;
	logic [31:0]        t_sum;
	logic [HASH_W-1:0]  hash_nxt;
	logic [COUNT_W:0]   trial;
	logic [COUNT_W:0]   diff;

	always_comb begin
		c_fold = byte_beat.char_byte;
		if (case_fold_q && (byte_beat.char_byte inside {[8'h41:8'h5A]})) begin
			c_fold = byte_beat.char_byte + 8'h20;
		end
		t_sum    = {hash_q, 4'b0000} + {24'd0, c_fold};
		hash_nxt = {t_sum[27:8], t_sum[7:4] ^ t_sum[31:28], t_sum[3:0]};
	end

	// restoring step; a zero divisor leaves the dividend as remainder
	assign trial = {rem_q, dvd_q[HASH_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			case_fold_q    <= 1'b0;
			bucket_count_q <= BUCKET_COUNT_RST;
			hash_q         <= '0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_CASE_FOLD:    case_fold_q    <= cfg_data[0];
					REG_BUCKET_COUNT: bucket_count_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.hash_en) begin
				hash_q <= byte_beat.last_byte ? '0 : hash_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			hash_hold_q <= hash_nxt;
			dvd_q       <= hash_nxt;
			rem_q       <= '0;
			dsr_q       <= bucket_count_q;
		end else if (cmd.step) begin
			dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= diff[COUNT_W-1:0];
			end else begin
				rem_q <= trial[COUNT_W-1:0];
			end
		end
		if (cmd.load_out) begin
			out_q.hash_value   <= hash_hold_q;
			out_q.bucket_index <= rem_q[HASH_W-1:0];
		end
	end

	assign result_beat = out_q;

endmodule

// ===== rtl/elf_hash_bucket_index.sv =====
// ----------------------------------------------------------------------------
// elf_hash_bucket_index
// PJW/ELF hash of a streamed symbol name with bucket index by modulo.
//
//   channel  | handshake                  | beat
//   byte     | byte_valid / byte_stall    | byte_beat   (char_byte, last_byte)
//   result   | result_valid / result_stall| result_beat (hash_value, bucket_index)
//   config   | cfg_wen                    | cfg_index, cfg_data
//
// Non-last bytes are taken one per cycle, also while a modulo is running.
// A last byte starts a 28-step restoring modulo (one bit per cycle); after
// the last step the result is loaded once the output register is free.
// A last byte is stalled while the modulo unit is busy or its result waits.
// The output register holds one result; result_stall keeps it in place.
// Reset clears the running hash and loads case_fold 0, bucket_count 1024.
// ----------------------------------------------------------------------------
module elf_hash_bucket_index
	import ehbi_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COUNT_W-1:0]   cfg_data,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  ehbi_in_t             byte_beat,
	output logic                 result_valid,
	input  logic                 result_stall,
	output ehbi_out_t            result_beat
);

	ehbi_cmd_t cmd;

	ehbi_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.last_byte    (byte_beat.last_byte),
		.byte_stall   (byte_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	ehbi_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.byte_beat   (byte_beat),
		.cmd         (cmd),
		.result_beat (result_beat)
	);

endmodule

// ===== tb/ehbi_hash_checker.sv =====
// ----------------------------------------------------------------------------
// ehbi_hash_checker
// Watches the byte, result and config ports of the ELF hash bucket index
// block. It keeps its own copy of the running hash and the registers, predicts
// hash and bucket for every last-byte beat, and compares each result beat,
// in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module ehbi_hash_checker
	import ehbi_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COUNT_W-1:0]   cfg_data,
	input  logic                 byte_valid,
	input  logic                 byte_stall,
	input  ehbi_in_t             byte_beat,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  ehbi_out_t            result_beat,
	output int                   fail_count,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] TOP_NIBBLE = 32'hF000_0000;
	localparam int          FOLD_SHIFT = 24;
	localparam int          STEP_SHIFT = 4;
	localparam int          MAX_NOTES  = 40;

	logic                fold_mode;
	logic [COUNT_W-1:0]  buckets;
	logic [HASH_W-1:0]   partial_hash;
	ehbi_out_t           owed_hashes[$];

	function automatic logic [HASH_W-1:0] pjw_mix(logic [HASH_W-1:0] h, logic [7:0] c,
		logic fold);
		logic [7:0]  b;
		logic [31:0] t;
		logic [31:0] top;
		b = c;
		if (fold && c >= 8'h41 && c <= 8'h5A) begin
			b = c + 8'h20;
		end
		t = (32'(h) << STEP_SHIFT) + 32'(b);
		top = t & TOP_NIBBLE;
		t = t ^ (top >> FOLD_SHIFT);
		t = t & ~top;
		return t[HASH_W-1:0];
	endfunction

	function automatic logic [HASH_W-1:0] bucket_of(logic [HASH_W-1:0] h,
		logic [COUNT_W-1:0] n);
		logic [COUNT_W-1:0] r;
		if (n == '0) begin
			return h;
		end
		r = {1'b0, h} % n;
		return r[HASH_W-1:0];
	endfunction

	task automatic report(string what, logic [HASH_W-1:0] got, logic [HASH_W-1:0] want);
		if (fail_count < MAX_NOTES) begin
			$display("%0t ns mismatch %s: got %h want %h", $realtime, what, got, want);
		end
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		ehbi_out_t         want;
		logic [HASH_W-1:0] h;
		if (!arst_n) begin
			fold_mode = 1'b0;
			buckets = BUCKET_COUNT_RST;
			partial_hash = '0;
			owed_hashes.delete();
		end else begin
			if (result_valid && !result_stall) begin
				if (owed_hashes.size() == 0) begin
					report("result beat with none owed", result_beat.hash_value, '0);
				end else begin
					want = owed_hashes.pop_front();
					if (result_beat.hash_value !== want.hash_value) begin
						report("hash_value", result_beat.hash_value, want.hash_value);
					end
					if (result_beat.bucket_index !== want.bucket_index) begin
						report("bucket_index", result_beat.bucket_index, want.bucket_index);
					end
				end
			end
			if (byte_valid && !byte_stall) begin
				h = pjw_mix(partial_hash, byte_beat.char_byte, fold_mode);
				if (byte_beat.last_byte) begin
					owed_hashes.push_back('{hash_value: h, bucket_index: bucket_of(h, buckets)});
					partial_hash = '0;
				end else begin
					partial_hash = h;
				end
			end
			if (cfg_wen) begin
				if (cfg_index == REG_CASE_FOLD) begin
					fold_mode = cfg_data[0];
				end else if (cfg_index == REG_BUCKET_COUNT) begin
					buckets = cfg_data;
				end
			end
		end
		pending = owed_hashes.size();
	end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Regression for the ELF hash bucket index block. A short directed run hits
// byte extremes, the top-nibble fold, case folding at the letter borders,
// zero/one/huge bucket counts, ignored register indexes and register writes
// in mid-name; then three random phases of symbol names run under changing
// sender and receiver idling, one long result hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb;
	import ehbi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE      = 40;
	localparam int HOLD_OFF    = 400;
	localparam int PHASE_BYTES = 500;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam logic [COUNT_W-1:0]   COUNT_MAX   = '1;
	localparam logic [COUNT_W-1:0]   COUNT_TOP   = 29'h1000_0000;
	localparam logic [7:0] BORDER_CHARS [8] = '{8'h40, 8'h41, 8'h5A, 8'h5B,
		8'h60, 8'h7B, 8'hC1, 8'hDA};

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_wen      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [COUNT_W-1:0]   cfg_data     = '0;
	logic                 byte_valid   = 1'b0;
	logic                 byte_stall;
	ehbi_in_t             byte_beat    = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	ehbi_out_t            result_beat;
	logic                 hold_go      = 1'b0;
	logic                 hold_done    = 1'b0;

	int fail_count;
	int pending;
	int cycles        = 0;
	int hold_left     = 0;
	int send_idle_pct = 25;
	int recv_idle_pct = 25;
	int bytes_sent    = 0;

	always #6 clk = ~clk;

	elf_hash_bucket_index DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_beat    (byte_beat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_beat  (result_beat)
	);

	ehbi_hash_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_beat    (byte_beat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_beat  (result_beat),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: long hold-off when asked, else random stalls
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_left = HOLD_OFF;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] value);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	task automatic push_byte(logic [7:0] c, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_beat <= '{char_byte: c, last_byte: last};
		do @(posedge clk); while (byte_stall);
		bytes_sent++;
	endtask

	// all owed results in, then let the modulo unit settle
	task automatic drain();
		byte_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [7:0] name_char();
		case ($urandom_range(3))
			0: return 8'h41 + 8'($urandom_range(25));
			1: return 8'h61 + 8'($urandom_range(25));
			2: return BORDER_CHARS[3'($urandom_range(7))];
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic run_phase(int send_pct, int recv_pct);
		int target;
		int len;
		target = bytes_sent + PHASE_BYTES;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		while (bytes_sent < target) begin
			if ($urandom_range(39) == 0) begin
				byte_valid <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
			end
			len = ($urandom_range(7) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 10);
			for (int i = 1; i <= len; i++) begin
				push_byte(name_char(), i == len);
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: no folding, 1024 buckets
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h41, 1'b1);
		repeat (7) push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b1);

		drain();
		write_reg(REG_CASE_FOLD, COUNT_MAX);
		push_byte(8'h40, 1'b0);
		push_byte(8'h41, 1'b0);
		push_byte(8'h5A, 1'b0);
		push_byte(8'h5B, 1'b0);
		push_byte(8'h61, 1'b0);
		push_byte(8'h80, 1'b1);

		drain();
		write_reg(REG_BUCKET_COUNT, '0);
		push_byte(8'h7A, 1'b1);
		drain();
		write_reg(REG_BUCKET_COUNT, 29'd1);
		push_byte(8'hC3, 1'b1);
		drain();
		write_reg(REG_BUCKET_COUNT, COUNT_TOP);
		push_byte(8'hFF, 1'b1);
		drain();
		write_reg(REG_BUCKET_COUNT, COUNT_MAX);
		push_byte(8'h3C, 1'b1);

		// unused indexes must not touch anything
		drain();
		write_reg(REG_SPARE_A, '0);
		write_reg(REG_SPARE_B, COUNT_MAX);
		push_byte(8'h5A, 1'b1);

		// writes in the middle of a name
		drain();
		write_reg(REG_BUCKET_COUNT, 29'd7);
		push_byte(8'h51, 1'b0);
		drain();
		write_reg(REG_CASE_FOLD, '0);
		write_reg(REG_BUCKET_COUNT, 29'd3);
		push_byte(8'h51, 1'b1);

		drain();
		write_reg(REG_CASE_FOLD, 29'd1);
		write_reg(REG_BUCKET_COUNT, '0);
		hold_go = 1'b1;
		run_phase(32, 56);

		drain();
		write_reg(REG_CASE_FOLD, '0);
		write_reg(REG_BUCKET_COUNT, COUNT_TOP);
		run_phase(56, 32);

		drain();
		write_reg(REG_CASE_FOLD, COUNT_W'($urandom_range(1)));
		write_reg(REG_BUCKET_COUNT, COUNT_W'($urandom_range(1, 5000)));
		run_phase(0, 0);

		drain();
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ehbi_pkg.sv
rtl/ehbi_ctrl.sv
rtl/ehbi_datapath.sv
rtl/elf_hash_bucket_index.sv
tb/ehbi_hash_checker.sv
tb/tb.sv
